[rtl/core/bgc_pkg.sv]
// ----------------------------------------------------------------------------
// bgc_pkg: button gesture classifier package
// Shared widths, codes and structs of the classifier and its button machines.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int NUM_BUTTONS  = 6;
    localparam int TIMER_WIDTH  = 16;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = 1;
    localparam int FIFO_CNT_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MASK  = 2'd3;

    localparam logic [TIMER_WIDTH-1:0] RST_DOUBLE_CLICK = 16'd300;
    localparam logic [TIMER_WIDTH-1:0] RST_LONG_PRESS   = 16'd700;
    localparam logic [TIMER_WIDTH-1:0] RST_REPEAT       = 16'd200;
    localparam logic [NUM_BUTTONS-1:0] RST_REPEAT_MASK  = 6'd12;

    typedef enum logic [1:0] {
        G_SINGLE = 2'd0,
        G_DOUBLE = 2'd1,
        G_LONG   = 2'd2,
        G_REPEAT = 2'd3
    } t_gesture;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_WINDOW = 4'b0010,
        PH_LONG   = 4'b0100,
        PH_REPEAT = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] double_click_ticks;
        logic [TIMER_WIDTH-1:0] long_press_ticks;
        logic [TIMER_WIDTH-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        t_gesture gesture;
    } t_event;

endpackage

[rtl/core/bgc_in_if.sv]
// ----------------------------------------------------------------------------
// bgc_in_if: tick channel
// Valid/ready channel carrying the sampled button levels of one tick.
// ----------------------------------------------------------------------------
interface bgc_in_if;

    logic                          valid;
    logic                          ready;
    logic [bgc_pkg::NUM_BUTTONS-1:0] button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);

endinterface

[rtl/core/bgc_out_if.sv]
// ----------------------------------------------------------------------------
// bgc_out_if: gesture event channel
// Valid/ready channel carrying one classified gesture event per transfer.
// ----------------------------------------------------------------------------
interface bgc_out_if;

    logic                    valid;
    logic                    ready;
    logic [bgc_pkg::IDX_W-1:0] button_index;
    logic [1:0]              gesture;
    logic                    last_event;

    modport source (output valid, output button_index, output gesture,
                    output last_event, input ready);
    modport sink   (input valid, input button_index, input gesture,
                    input last_event, output ready);

endinterface

[rtl/core/bgc_button.sv]
// ----------------------------------------------------------------------------
// bgc_button: per-button gesture machine
// Holds phase and countdown of one button, reports its event for the tick.
// ----------------------------------------------------------------------------
module bgc_button (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_now_rel,
    input  logic              i_was_rel,
    input  logic              i_rep_en,
    input  bgc_pkg::t_cfg     i_cfg,
    output bgc_pkg::t_event   o_event
);

    bgc_pkg::t_phase                   r_phase, n_phase;
    logic [bgc_pkg::TIMER_WIDTH-1:0]   r_count, n_count;

    always_comb begin
        logic press;
        logic release_edge;
        logic touched;
        press        = i_was_rel && !i_now_rel;
        release_edge = !i_was_rel && i_now_rel;
        touched      = 1'b0;
        n_phase      = r_phase;
        n_count      = r_count;
        o_event      = '{valid: 1'b0, gesture: bgc_pkg::G_SINGLE};

        if (press) begin
            touched = 1'b1;
            if (r_phase == bgc_pkg::PH_WINDOW) begin
                o_event = '{valid: 1'b1, gesture: bgc_pkg::G_DOUBLE};
                n_phase = bgc_pkg::PH_IDLE;
                n_count = '0;
            end else begin
                n_phase = bgc_pkg::PH_WINDOW;
                n_count = i_cfg.double_click_ticks;
            end
        end else if (release_edge &&
                     (r_phase == bgc_pkg::PH_LONG || r_phase == bgc_pkg::PH_REPEAT)) begin
            touched = 1'b1;
            n_phase = bgc_pkg::PH_IDLE;
            n_count = '0;
        end

        if (!touched) begin
            if (r_count > bgc_pkg::TIMER_WIDTH'(1)) begin
                if (r_phase != bgc_pkg::PH_IDLE) begin
                    n_count = r_count - bgc_pkg::TIMER_WIDTH'(1);
                end
            end else begin
                case (r_phase)
                    bgc_pkg::PH_IDLE: begin
                    end
                    bgc_pkg::PH_WINDOW: begin
                        if (i_now_rel) begin
                            o_event = '{valid: 1'b1, gesture: bgc_pkg::G_SINGLE};
                            n_phase = bgc_pkg::PH_IDLE;
                            n_count = '0;
                        end else begin
                            n_phase = bgc_pkg::PH_LONG;
                            n_count = i_cfg.long_press_ticks;
                        end
                    end
                    bgc_pkg::PH_LONG, bgc_pkg::PH_REPEAT: begin
                        if (r_phase == bgc_pkg::PH_LONG) begin
                            o_event = '{valid: 1'b1, gesture: bgc_pkg::G_LONG};
                        end else if (i_rep_en) begin
                            o_event = '{valid: 1'b1, gesture: bgc_pkg::G_REPEAT};
                        end
                        if (!i_now_rel) begin
                            n_phase = bgc_pkg::PH_REPEAT;
                            n_count = i_cfg.repeat_ticks;
                        end else begin
                            n_phase = bgc_pkg::PH_IDLE;
                            n_count = '0;
                        end
                    end
                    default: begin
                        n_phase = bgc_pkg::PH_IDLE;
                        n_count = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bgc_pkg::PH_IDLE;
            r_count <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/button_gesture_classifier_unit.sv]
// ----------------------------------------------------------------------------
// button_gesture_classifier_unit: button gesture classifier top level
// Six parallel button machines classify clicks, double clicks, long presses
// and repeats; events of a tick drain one per transfer in button order.
//
//   channel   dir   payload                                 handshake
//   i_in      in    button_levels[5:0]                      valid/ready
//   o_out     out   button_index[2:0] gesture[1:0] last     valid/ready
//   cfg       in    i_cfg_index[1:0] i_cfg_data[15:0]       i_cfg_we
//
// a tick is taken when valid and ready are both high; all button machines update at that edge
// the tick's events enter a two-entry event queue, one event leaves per cycle while o_out.ready is high
// a tick with k events holds one queue entry until all k have left; i_in.ready drops
// only while both entries are occupied
// synchronous active-low reset: all buttons released and idle, queue empty
// ----------------------------------------------------------------------------
module button_gesture_classifier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bgc_in_if.sink                         i_in,
    bgc_out_if.source                      o_out
);

    localparam int NB = bgc_pkg::NUM_BUTTONS;

    bgc_pkg::t_cfg                  r_cfg;
    logic [NB-1:0]                  r_mask;
    logic [NB-1:0]                  r_prev;

    logic [NB-1:0]                  r_q_mask [bgc_pkg::FIFO_DEPTH];
    logic [NB-1:0][1:0]             r_q_gest [bgc_pkg::FIFO_DEPTH];
    logic [bgc_pkg::FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bgc_pkg::FIFO_CNT_W-1:0] r_fill, n_fill;

    bgc_pkg::t_event                events [NB];
    logic [NB-1:0]                  ev_mask;
    logic [NB-1:0][1:0]             ev_gest;
    logic                           tick;
    logic                           push;
    logic                           pop;
    logic                           out_xfer;

    logic [NB-1:0]                  head_mask;
    logic [NB-1:0][1:0]             head_gest;
    logic [NB-1:0]                  sel_onehot;
    logic [bgc_pkg::IDX_W-1:0]      sel_idx;
    logic                           sel_last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.double_click_ticks <= bgc_pkg::RST_DOUBLE_CLICK;
            r_cfg.long_press_ticks   <= bgc_pkg::RST_LONG_PRESS;
            r_cfg.repeat_ticks       <= bgc_pkg::RST_REPEAT;
            r_mask                   <= bgc_pkg::RST_REPEAT_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bgc_pkg::CFG_DOUBLE_CLICK: r_cfg.double_click_ticks <= i_cfg_data;
                bgc_pkg::CFG_LONG_PRESS:   r_cfg.long_press_ticks   <= i_cfg_data;
                bgc_pkg::CFG_REPEAT:       r_cfg.repeat_ticks       <= i_cfg_data;
                bgc_pkg::CFG_REPEAT_MASK:  r_mask                   <= i_cfg_data[NB-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = (r_fill != bgc_pkg::FIFO_CNT_W'(bgc_pkg::FIFO_DEPTH));
    assign tick       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '1;
        end else if (tick) begin
            r_prev <= i_in.button_levels;
        end
    end

    for (genvar g = 0; g < NB; g++) begin : g_btn
        bgc_button u_button (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tick    (tick),
            .i_now_rel (i_in.button_levels[g]),
            .i_was_rel (r_prev[g]),
            .i_rep_en  (r_mask[g]),
            .i_cfg     (r_cfg),
            .o_event   (events[g])
        );
        assign ev_mask[g] = events[g].valid;
        assign ev_gest[g] = events[g].gesture;
    end

    assign push = tick && (ev_mask != '0);

    // head of queue: lowest pending button goes out first
    assign head_mask = r_q_mask[r_rd_ptr];
    assign head_gest = r_q_gest[r_rd_ptr];

    always_comb begin
        sel_idx    = '0;
        sel_onehot = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (head_mask[i]) begin
                sel_idx    = bgc_pkg::IDX_W'(i);
                sel_onehot = NB'(1) << i;
            end
        end
        sel_last = ((head_mask & ~sel_onehot) == '0);
    end

    assign o_out.valid        = (r_fill != '0);
    assign o_out.button_index = sel_idx;
    assign o_out.gesture      = head_gest[sel_idx];
    assign o_out.last_event   = sel_last;

    assign out_xfer = o_out.valid && o_out.ready;
    assign pop      = out_xfer && sel_last;

    always_comb begin
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + bgc_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - bgc_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + bgc_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + bgc_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    // queue storage, push and drain never touch the same entry
    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_q_mask[r_rd_ptr] <= head_mask & ~sel_onehot;
        end
        if (push) begin
            r_q_mask[r_wr_ptr] <= ev_mask;
            r_q_gest[r_wr_ptr] <= ev_gest;
        end
    end

endmodule
